// ===== rtl/core/chained_hash_map_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Chained hash map engine assertion macros
// Shared property forms for the checker, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_ENGINE_DEFINES_SVH
`define CHAINED_HASH_MAP_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHME_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/chme_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained hash map engine package
// Field widths, request codes, controller states and the walk finish record.
// ----------------------------------------------------------------------------
package chme_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int COUNT_W    = 11;
  localparam int HASH_SHIFT = 16;
  localparam int IN_W       = 72;
  localparam int OUT_W      = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_ACT,
    S_LINK,
    S_OUT
  } state_t;

  // Reported by a walk cell when the chain search ends in that cell.
  typedef struct packed {
    logic done;
    logic hit;
  } walk_fin_t;

endpackage

// ===== rtl/core/chained_hash_map_engine.sv =====
// ----------------------------------------------------------------------------
// Chained hash map engine
// Map from 32-bit keys to 32-bit values kept as separate chains in a pool of
// entries; chains are searched by a ring of walk cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  op, key, value
//  m_*       out        m_tvalid/m_tready  found, value_out, count, status
//
// A request passes through head read, a walk of a non-empty chain by the ring
// of walk cells (one entry memory read per cycle), action and output, plus a
// link step for a new key. Clear goes to output, then sweeps all BIN_COUNT bin
// heads. After reset the same sweep runs with s_tready low.
// A request is taken while a finished result still waits in the output
// register; its own result then waits until that register is free.
module chained_hash_map_engine import chme_pkg::*; #(
  parameter int BIN_COUNT    = 256,
  parameter int POOL_ENTRIES = 1024,
  parameter int CELL_COUNT   = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // op[1:0], key[33:2], value[65:34], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // found[0], value_out[32:1], count[43:33],
                                      // status[44], zero pad
);

  localparam int BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int PW = $clog2(POOL_ENTRIES + 1);
  localparam logic [PW-1:0]    NO_ENTRY = PW'(POOL_ENTRIES);
  localparam logic [BW-1:0]    BIN_LAST = BW'(BIN_COUNT - 1);
  localparam logic [KEY_W-1:0] BIN_MASK = KEY_W'(BIN_COUNT - 1);

  state_t state, state_next;

  // Request fields
  op_t              in_op;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_val;
  logic [KEY_W-1:0] in_hash;
  logic [BW-1:0]    in_bin;
  logic             acc;

  op_t              req_op;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_val;
  logic [BW-1:0]    req_bin;

  // Bin heads
  logic [PW-1:0] bin_head [BIN_COUNT];
  logic          bh_we;
  logic [BW-1:0] bh_waddr;
  logic [PW-1:0] bh_wdata;
  logic [PW-1:0] bh_rd;
  logic [BW-1:0] swp;

  // Entry pool
  logic [KEY_W-1:0] ent_key  [POOL_ENTRIES];
  logic [VAL_W-1:0] ent_val  [POOL_ENTRIES];
  logic [PW-1:0]    ent_link [POOL_ENTRIES];
  logic             ek_we;
  logic             ev_we;
  logic [IW-1:0]    e_waddr;
  logic             el_we;
  logic [IW-1:0]    el_waddr;
  logic [PW-1:0]    el_wdata;
  logic [IW-1:0]    e_raddr;
  logic [PW-1:0]    e_raddr_p;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [PW-1:0]    rd_link;

  // Free entries: a stack of returned indices plus the index of the next never used one
  logic [IW-1:0] stk_mem [POOL_ENTRIES];
  logic [PW-1:0] stk_cnt, stk_cnt_next;
  logic [IW-1:0] stk_raddr;
  logic [IW-1:0] stk_top;
  logic          stk_we;
  logic [PW-1:0] fresh, fresh_next;
  logic [PW-1:0] cnt, cnt_next;
  logic          alloc;
  logic [IW-1:0] alloc_idx;
  logic [IW-1:0] new_idx;

  // Walk ring
  logic          inject;
  logic          c_vin     [CELL_COUNT];
  logic [PW-1:0] c_cur_in  [CELL_COUNT];
  logic [PW-1:0] c_prev_in [CELL_COUNT];
  logic          c_vout    [CELL_COUNT];
  logic [PW-1:0] c_cur_out [CELL_COUNT];
  logic [PW-1:0] c_prev_out[CELL_COUNT];
  walk_fin_t     c_fin     [CELL_COUNT];
  logic [PW-1:0] c_fin_cur [CELL_COUNT];
  logic [PW-1:0] c_fin_prev[CELL_COUNT];
  logic          fin_done;
  logic          fin_hit;
  logic [PW-1:0] fin_cur;
  logic [PW-1:0] fin_prev;

  // Search outcome
  logic             hit;
  logic [IW-1:0]    hit_idx;
  logic [PW-1:0]    prv;
  logic [VAL_W-1:0] hit_val;
  logic [PW-1:0]    hit_link;

  // Result
  logic             res_ld;
  logic             res_found, res_found_next;
  logic [VAL_W-1:0] res_val, res_val_next;
  logic             res_st, res_st_next;
  logic             load_out;

  assign in_op   = op_t'(s_tdata[1:0]);
  assign in_key  = s_tdata[33:2];
  assign in_val  = s_tdata[65:34];
  assign in_hash = in_key ^ (in_key >> HASH_SHIFT);
  assign in_bin  = BW'(in_hash & BIN_MASK);
  assign acc     = s_tvalid && s_tready;

  assign stk_raddr = IW'(stk_cnt - PW'(1));
  assign alloc_idx = (stk_cnt != '0) ? stk_top : fresh[IW-1:0];

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (bh_we) begin
      bin_head[bh_waddr] <= bh_wdata;
    end
    bh_rd <= bin_head[in_bin];
  end

  always_ff @(posedge clk) begin
    if (ek_we) begin
      ent_key[e_waddr] <= req_key;
    end
    rd_key <= ent_key[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      ent_val[e_waddr] <= req_val;
    end
    rd_val <= ent_val[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (el_we) begin
      ent_link[el_waddr] <= el_wdata;
    end
    rd_link <= ent_link[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_cnt[IW-1:0]] <= hit_idx;
    end
    if (acc) begin
      stk_top <= stk_mem[stk_raddr];
    end
  end

  // --------------------------------------------------------------- walk ring
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    localparam int PI = (i == 0) ? CELL_COUNT - 1 : i - 1;

    if (i == 0) begin : g_head
      assign c_vin[i]     = inject || c_vout[PI];
      assign c_cur_in[i]  = inject ? bh_rd : c_cur_out[PI];
      assign c_prev_in[i] = inject ? NO_ENTRY : c_prev_out[PI];
    end else begin : g_body
      assign c_vin[i]     = c_vout[PI];
      assign c_cur_in[i]  = c_cur_out[PI];
      assign c_prev_in[i] = c_prev_out[PI];
    end

    chme_cell #(
      .POOL_ENTRIES(POOL_ENTRIES)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (c_vin[i]),
      .in_cur   (c_cur_in[i]),
      .in_prev  (c_prev_in[i]),
      .key      (req_key),
      .rd_key   (rd_key),
      .rd_link  (rd_link),
      .out_vld  (c_vout[i]),
      .out_cur  (c_cur_out[i]),
      .out_prev (c_prev_out[i]),
      .fin      (c_fin[i]),
      .fin_cur  (c_fin_cur[i]),
      .fin_prev (c_fin_prev[i])
    );
  end

  // At most one cell is active, so its address and outcome are gathered by OR.
  always_comb begin
    e_raddr_p = inject ? bh_rd : '0;
    fin_done  = 1'b0;
    fin_hit   = 1'b0;
    fin_cur   = '0;
    fin_prev  = '0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      if (c_vout[i]) begin
        e_raddr_p = e_raddr_p | c_cur_out[i];
      end
      if (c_fin[i].done) begin
        fin_done = 1'b1;
        fin_hit  = fin_hit | c_fin[i].hit;
        fin_cur  = fin_cur | c_fin_cur[i];
        fin_prev = fin_prev | c_fin_prev[i];
      end
    end
  end

  assign e_raddr = e_raddr_p[IW-1:0];

  // ------------------------------------------------------------- controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    bh_we          = 1'b0;
    bh_waddr       = req_bin;
    bh_wdata       = NO_ENTRY;
    ek_we          = 1'b0;
    ev_we          = 1'b0;
    e_waddr        = hit_idx;
    el_we          = 1'b0;
    el_waddr       = prv[IW-1:0];
    el_wdata       = NO_ENTRY;
    inject         = 1'b0;
    stk_we         = 1'b0;
    alloc          = 1'b0;
    res_ld         = 1'b0;
    res_found_next = 1'b0;
    res_val_next   = '0;
    res_st_next    = 1'b0;
    cnt_next       = cnt;
    fresh_next     = fresh;
    stk_cnt_next   = stk_cnt;
    load_out       = 1'b0;

    case (state)
      S_SWEEP: begin
        bh_we    = 1'b1;
        bh_waddr = swp;
        if (swp == BIN_LAST) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_op == OP_CLEAR) begin
            cnt_next     = '0;
            fresh_next   = '0;
            stk_cnt_next = '0;
            res_ld       = 1'b1;
            state_next   = S_OUT;
          end else begin
            state_next = S_HEAD;
          end
        end
      end

      S_HEAD: begin
        if (bh_rd >= NO_ENTRY) begin
          state_next = S_ACT;
        end else begin
          inject     = 1'b1;
          state_next = S_WALK;
        end
      end

      S_WALK: begin
        if (fin_done) begin
          state_next = S_ACT;
        end
      end

      S_ACT: begin
        res_ld     = 1'b1;
        state_next = S_OUT;
        case (req_op)
          OP_PUT: begin
            if (hit) begin
              ev_we          = 1'b1;
              res_found_next = 1'b1;
            end else if (cnt >= NO_ENTRY) begin
              res_st_next = 1'b1;
            end else begin
              ek_we    = 1'b1;
              ev_we    = 1'b1;
              e_waddr  = alloc_idx;
              el_we    = 1'b1;
              el_waddr = alloc_idx;
              el_wdata = NO_ENTRY;
              alloc    = 1'b1;
              if (stk_cnt != '0) begin
                stk_cnt_next = stk_cnt - PW'(1);
              end else begin
                fresh_next = fresh + PW'(1);
              end
              cnt_next   = cnt + PW'(1);
              state_next = S_LINK;
            end
          end
          OP_GET: begin
            res_found_next = hit;
            res_val_next   = hit ? hit_val : '0;
          end
          OP_REMOVE: begin
            res_found_next = hit;
            res_val_next   = hit ? hit_val : '0;
            if (hit) begin
              // Unlink from the previous entry, or from the bin head when the
              // entry is first in its chain.
              if (prv < NO_ENTRY) begin
                el_we    = 1'b1;
                el_wdata = hit_link;
              end else begin
                bh_we    = 1'b1;
                bh_wdata = hit_link;
              end
              stk_we       = 1'b1;
              stk_cnt_next = stk_cnt + PW'(1);
              cnt_next     = cnt - PW'(1);
            end
          end
          default: begin
          end
        endcase
      end

      S_LINK: begin
        if (prv < NO_ENTRY) begin
          el_we    = 1'b1;
          el_wdata = PW'(new_idx);
        end else begin
          bh_we    = 1'b1;
          bh_wdata = PW'(new_idx);
        end
        state_next = S_OUT;
      end

      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = (req_op == OP_CLEAR) ? S_SWEEP : S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swp     <= '0;
      cnt     <= '0;
      fresh   <= '0;
      stk_cnt <= '0;
    end else begin
      if (state == S_SWEEP) begin
        swp <= (swp == BIN_LAST) ? '0 : swp + BW'(1);
      end
      cnt     <= cnt_next;
      fresh   <= fresh_next;
      stk_cnt <= stk_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      req_op  <= in_op;
      req_key <= in_key;
      req_val <= in_val;
      req_bin <= in_bin;
    end
    if (state == S_HEAD) begin
      hit <= 1'b0;
      prv <= NO_ENTRY;
    end
    if (state == S_WALK && fin_done) begin
      hit      <= fin_hit;
      hit_idx  <= fin_cur[IW-1:0];
      prv      <= fin_prev;
      hit_val  <= rd_val;
      hit_link <= rd_link;
    end
    if (alloc) begin
      new_idx <= alloc_idx;
    end
    if (res_ld) begin
      res_found <= res_found_next;
      res_val   <= res_val_next;
      res_st    <= res_st_next;
    end
  end

  // ------------------------------------------------------------ output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {3'b000, res_st, COUNT_W'(cnt), res_val, res_found};
    end
  end

endmodule

// ===== rtl/core/chme_cell.sv =====
// ----------------------------------------------------------------------------
// Chained hash map walk cell
// One step of a chain walk: compares the fetched entry against the key and
// either ends the search or hands the link on to the next cell of the ring.
// ----------------------------------------------------------------------------
module chme_cell import chme_pkg::*; #(
  parameter int POOL_ENTRIES = 1024,
  localparam int PW = $clog2(POOL_ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [PW-1:0]    in_cur,
  input  logic [PW-1:0]    in_prev,
  input  logic [KEY_W-1:0] key,
  input  logic [KEY_W-1:0] rd_key,
  input  logic [PW-1:0]    rd_link,
  output logic             out_vld,
  output logic [PW-1:0]    out_cur,
  output logic [PW-1:0]    out_prev,
  output walk_fin_t        fin,
  output logic [PW-1:0]    fin_cur,
  output logic [PW-1:0]    fin_prev
);

  localparam logic [PW-1:0] NO_ENTRY = PW'(POOL_ENTRIES);

  logic          vld;
  logic [PW-1:0] cur;
  logic [PW-1:0] prev;
  logic          match;
  logic          tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    cur  <= in_cur;
    prev <= in_prev;
  end

  // The entry memory was addressed with cur in the previous cycle, so its read data
  // belongs to the entry this cell holds.
  assign match = vld && (rd_key == key);
  assign tail  = rd_link >= NO_ENTRY;

  assign out_vld  = vld && !match && !tail;
  assign out_cur  = rd_link;
  assign out_prev = cur;

  assign fin.done = vld && (match || tail);
  assign fin.hit  = match;
  assign fin_cur  = cur;
  // On a miss the last entry visited is the chain tail.
  assign fin_prev = match ? prev : cur;

endmodule

// ===== rtl/core/chme_checker.sv =====
// ----------------------------------------------------------------------------
// Chained hash map engine checker
// Port-level properties of the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "chained_hash_map_engine_defines.svh"

module chme_checker import chme_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `CHME_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Every request leaves s_tready low after it is taken, so requests are never taken back to back.
  `CHME_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request taken in back-to-back cycles")

  `CHME_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[32:1] == 32'd0, "value given for a key not found")

  `CHME_ASSERT_SAME(a_refuse, m_tvalid && m_tdata[44], !m_tdata[0] && m_tdata[32:1] == 32'd0, "refused put reports a found key")

endmodule

bind chained_hash_map_engine chme_checker u_chme_checker (.*);
